@@ design/clcd_pkg.sv @@
package clcd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 1'd1;

    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_NL         = 8'd10;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] SPACE_CODE    = 8'h20;
    localparam logic [7:0] ODD_ROW_BASE  = 8'h40;
    localparam logic [7:0] SET_ADDR_FLAG = 8'h80;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;
    localparam int         TAB_SPACES    = 4;

    localparam logic       CMD_CHAR      = 1'b0;
    localparam logic       CMD_SET_POS   = 1'b1;

    localparam logic [5:0] COLUMNS_RESET = 6'd16;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic [7:0] row;
        logic [7:0] column;
    } t_in_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_value;
        logic       last;
    } t_out_item;

    // one burst of bus writes: the same byte, possibly repeated and split into nibbles
    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
        logic       nibble;
        logic [2:0] last_idx;
    } t_desc;

endpackage

@@ design/clcd_decode.sv @@
module clcd_decode import clcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_desc_valid,
    input  logic                  i_desc_take,
    output t_desc                 o_desc
);

    logic       r_four_bit;
    logic [5:0] r_columns;
    logic [7:0] r_row;
    logic       r_dv;
    t_desc      r_desc;

    logic       w_accept;
    logic       w_set_pos;
    logic [7:0] w_pos_row;
    logic [7:0] w_pos_col;
    logic [7:0] w_addr;
    logic       w_tab;
    t_desc      n_desc;

    assign o_in_stall   = r_dv && !i_desc_take;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign o_desc_valid = r_dv;
    assign o_desc       = r_desc;

    always_comb begin
        w_set_pos = 1'b1;
        w_pos_row = r_row;
        w_pos_col = 8'd0;
        w_tab     = 1'b0;
        if (i_in.cmd == CMD_SET_POS) begin
            w_pos_row = i_in.row;
            w_pos_col = i_in.column;
        end else if (i_in.char_code == CH_NL) begin
            w_pos_row = r_row + 8'd1;
        end else if (i_in.char_code == CH_CR) begin
            w_pos_row = r_row;
        end else begin
            w_set_pos = 1'b0;
            w_tab     = (i_in.char_code == CH_TAB);
        end
    end

    always_comb begin
        w_addr = (w_pos_row[0] ? ODD_ROW_BASE : 8'd0)
               + ((w_pos_row > 8'd1) ? {2'b00, r_columns} : 8'd0)
               + w_pos_col;
    end

    always_comb begin
        n_desc.nibble = r_four_bit;
        if (w_set_pos) begin
            n_desc.is_data  = 1'b0;
            n_desc.value    = w_addr | SET_ADDR_FLAG;
            n_desc.last_idx = r_four_bit ? 3'd1 : 3'd0;
        end else if (w_tab) begin
            n_desc.is_data  = 1'b1;
            n_desc.value    = SPACE_CODE;
            n_desc.last_idx = r_four_bit ? 3'(2 * TAB_SPACES - 1) : 3'(TAB_SPACES - 1);
        end else begin
            n_desc.is_data  = 1'b1;
            n_desc.value    = i_in.char_code;
            n_desc.last_idx = r_four_bit ? 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b1;
            r_columns  <= COLUMNS_RESET;
            r_row      <= 8'd0;
            r_dv       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FOUR_BIT: r_four_bit <= i_cfg_data[0];
                    CFG_COLUMNS:  r_columns  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_dv <= 1'b1;
                if (w_set_pos) begin
                    r_row <= w_pos_row;
                end
            end else if (i_desc_take) begin
                r_dv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

@@ design/clcd_emit.sv @@
module clcd_emit import clcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_desc_valid,
    output logic      o_desc_take,
    input  t_desc     i_desc,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic      r_act;
    t_desc     r_desc;
    logic [2:0] r_idx;
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_advance;
    logic      w_is_last;
    logic      w_load;
    t_out_item n_out;

    assign w_advance   = r_act && (!r_out_vld || !i_out_stall);
    assign w_is_last   = (r_idx == r_desc.last_idx);
    assign w_load      = i_desc_valid && (!r_act || (w_advance && w_is_last));
    assign o_desc_take = w_load;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // even beat carries the high nibble, odd beat the low nibble
    always_comb begin
        n_out.is_data = r_desc.is_data;
        n_out.last    = w_is_last;
        if (!r_desc.nibble) begin
            n_out.bus_value = r_desc.value;
        end else if (r_idx[0]) begin
            n_out.bus_value = {4'd0, r_desc.value[3:0] & NIBBLE_MASK};
        end else begin
            n_out.bus_value = {4'd0, r_desc.value[7:4] & NIBBLE_MASK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_idx     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_load) begin
                r_act <= 1'b1;
                r_idx <= 3'd0;
            end else if (w_advance) begin
                if (w_is_last) begin
                    r_act <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_desc <= i_desc;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/char_lcd_text_stream_writer.sv @@
// text stream to character lcd bus writes
// input channel: i_in_valid / o_in_stall with one text item per beat (a character,
//   or a set-position request with row and column)
// output channel: o_out_valid / i_out_stall, one bus write per beat: register
//   select, byte or low-nibble value, and a last flag on the final write of an item
// config: i_cfg_we with i_cfg_index 0 = four-bit mode, 1 = column count
// an item becomes 1 write, 2 in four-bit mode; a tab becomes 4, or 8 in four-bit mode
// path: decode register, serializer descriptor register, then output register
// throughput: one output beat per cycle while i_out_stall is low; the write serializer
//   splits each item into its writes, and single-write items stream at one per cycle
// a decode register and the output register let a new item be taken while the
//   current one is still going out
// when the receiver stalls, the output beat holds and the serializer pauses; once
//   the decode register is also full, o_in_stall rises
// reset: no beats pending, stored row 0, four-bit mode on, 16 columns
module char_lcd_text_stream_writer import clcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out
);

    logic  w_desc_valid;
    logic  w_desc_take;
    t_desc w_desc;

    clcd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_desc_valid (w_desc_valid),
        .i_desc_take  (w_desc_take),
        .o_desc       (w_desc)
    );

    clcd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (w_desc_valid),
        .o_desc_take  (w_desc_take),
        .i_desc       (w_desc),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pending beats after reset");

    a_stall_needs_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_desc_valid)
        else $error("input stalled with empty decode register");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last |=> o_out_valid)
        else $error("gap inside a write burst");

    a_take_needs_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_desc_take |-> w_desc_valid)
        else $error("serializer took an empty descriptor");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import clcd_pkg::*;

    localparam int  PHASES          = 6;
    localparam int  ITEMS_PER_PHASE = 75;
    localparam int  MAX_IDLE        = 18;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  DRAIN_CYCLES    = 16;
    localparam int  REPORT_LIMIT    = 10;
    localparam real RUN_LIMIT_NS    = 2_000_000.0;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle_mode;

    class lcd_write_scoreboard;
        bit        four_bit;
        bit  [5:0] col_count;
        bit  [7:0] cur_row;
        t_out_item pending_writes[$];
        int        mismatches;

        function new();
            four_bit   = 1'b1;
            col_count  = COLUMNS_RESET;
            cur_row    = 8'd0;
            mismatches = 0;
        endfunction

        function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FOUR_BIT) begin
                four_bit = data[0];
            end else if (idx == CFG_COLUMNS) begin
                col_count = data;
            end
        endfunction

        function void push_byte(logic is_data, logic [7:0] b);
            if (four_bit) begin
                pending_writes.push_back('{is_data, {4'h0, b[7:4]}, 1'b0});
                pending_writes.push_back('{is_data, {4'h0, b[3:0] & NIBBLE_MASK}, 1'b0});
            end else begin
                pending_writes.push_back('{is_data, b, 1'b0});
            end
        endfunction

        function void position_cmd(logic [7:0] r, logic [7:0] c);
            logic [7:0] addr;
            addr = r[0] ? ODD_ROW_BASE : 8'h00;
            if (r > 8'd1) begin
                addr = addr + {2'b00, col_count};
            end
            addr = addr + c;
            push_byte(1'b0, addr | SET_ADDR_FLAG);
            cur_row = r;
        endfunction

        function void note_input(t_in_item it);
            if (it.cmd == CMD_SET_POS) begin
                position_cmd(it.row, it.column);
            end else if (it.char_code == CH_NL) begin
                position_cmd(cur_row + 8'd1, 8'd0);
            end else if (it.char_code == CH_CR) begin
                position_cmd(cur_row, 8'd0);
            end else if (it.char_code == CH_TAB) begin
                repeat (TAB_SPACES) push_byte(1'b1, SPACE_CODE);
            end else begin
                push_byte(1'b1, it.char_code);
            end
            pending_writes[pending_writes.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $write("%0t %s: expected is_data=%0d value=%02h last=%0d",
                       $realtime, what, want.is_data, want.bus_value, want.last);
                $display(", got is_data=%0d value=%02h last=%0d",
                         got.is_data, got.bus_value, got.last);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_writes.size() == 0) begin
                report("write with nothing pending", '0, got);
                return;
            end
            want = pending_writes.pop_front();
            if (got.is_data !== want.is_data || got.bus_value !== want.bus_value ||
                got.last !== want.last) begin
                report("bus write mismatch", want, got);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FOUR_BIT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;

    lcd_write_scoreboard sb;
    t_idle_mode          send_mode     = IDLE_FULL;
    t_idle_mode          recv_mode     = IDLE_FULL;
    bit                  hold_off_req  = 1'b0;

    char_lcd_text_stream_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_gap(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                return 0;
            end
            IDLE_FULL: begin
                return $urandom_range(0, MAX_IDLE);
            end
            default: begin
                return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
            end
        endcase
    endfunction

    function automatic t_idle_mode pick_mode();
        return t_idle_mode'($urandom_range(0, 2));
    endfunction

    function automatic t_in_item make_item(logic cmd, logic [7:0] ch, logic [7:0] r,
                                           logic [7:0] c);
        t_in_item it;
        it.cmd       = cmd;
        it.char_code = ch;
        it.row       = r;
        it.column    = c;
        return it;
    endfunction

    // mostly running text with line control, some cursor moves, some raw bytes
    function automatic t_in_item random_text_item();
        t_in_item it;
        int       sel;
        sel = $urandom_range(0, 99);
        it  = make_item(CMD_CHAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        if (sel < 15) begin
            it.cmd = CMD_SET_POS;
            if ($urandom_range(0, 1)) begin
                it.row    = 8'($urandom_range(0, 3));
                it.column = 8'($urandom_range(0, 39));
            end
        end else if (sel < 25) begin
            it.char_code = CH_NL;
        end else if (sel < 32) begin
            it.char_code = CH_CR;
        end else if (sel < 40) begin
            it.char_code = CH_TAB;
        end else if (sel < 65) begin
            it.char_code = 8'($urandom_range(8'h20, 8'h7E));
        end
        return it;
    endfunction

    // valid stays high across back-to-back beats
    task automatic send_text(input t_in_item it);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic stop_text();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending_writes.size() != 0);
    endtask

    task automatic write_settings(input bit four, input logic [5:0] cols);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FOUR_BIT;
        i_cfg_data  <= CFG_DATA_W'(four);
        @(posedge i_clk);
        sb.write_cfg(CFG_FOUR_BIT, CFG_DATA_W'(four));
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        sb.write_cfg(CFG_COLUMNS, cols);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out);
            end
        end
    end

    initial begin : receiver
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                // long hold so the block backs up into the input side
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) begin
                recv_mode = pick_mode();
            end
            wait_cycles = draw_gap(recv_mode);
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("char_lcd_text_stream_writer regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_in_item   directed[$];
        bit         phase_four [PHASES];
        logic [5:0] phase_cols [PHASES];

        sb = new();
        phase_four = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_cols = '{6'd40, 6'd1, 6'd0, 6'd63, 6'd16, 6'd16};
        phase_cols[4] = 6'($urandom_range(1, 40));
        phase_cols[5] = 6'($urandom_range(0, 63));

        // directed: reset settings, four-bit mode with 16 columns
        directed.push_back(make_item(CMD_CHAR, 8'h41, 8'hFF, 8'hFF));
        directed.push_back(make_item(CMD_CHAR, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, 8'hFF, 8'hAA, 8'h55));
        directed.push_back(make_item(CMD_CHAR, CH_TAB, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, CH_CR, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, CH_NL, 8'hFF, 8'hFF));
        directed.push_back(make_item(CMD_SET_POS, 8'hFF, 8'd0, 8'd0));
        directed.push_back(make_item(CMD_SET_POS, CH_NL, 8'd1, 8'd5));
        directed.push_back(make_item(CMD_SET_POS, CH_TAB, 8'd2, 8'd3));
        directed.push_back(make_item(CMD_SET_POS, 8'h00, 8'd3, 8'd15));
        // address sum past 8 bits
        directed.push_back(make_item(CMD_SET_POS, 8'h00, 8'd3, 8'd255));
        directed.push_back(make_item(CMD_SET_POS, 8'h55, 8'd255, 8'd255));
        // newline from the top row wraps to row zero
        directed.push_back(make_item(CMD_CHAR, CH_NL, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, CH_CR, 8'hFF, 8'hFF));
        directed.push_back(make_item(CMD_SET_POS, 8'hAA, 8'd254, 8'h80));
        directed.push_back(make_item(CMD_CHAR, CH_NL, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, CH_CR, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, CH_TAB, 8'hFF, 8'hFF));
        directed.push_back(make_item(CMD_CHAR, 8'h7F, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, 8'h80, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_CHAR, SPACE_CODE, 8'h00, 8'h00));
        directed.push_back(make_item(CMD_SET_POS, 8'h00, 8'd1, 8'd127));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            send_text(directed[k]);
        end
        stop_text();

        for (int p = 0; p < PHASES; p++) begin
            write_settings(phase_four[p], phase_cols[p]);
            if (p == 2) begin
                hold_off_req = 1'b1;
                send_mode    = IDLE_NONE;
            end else begin
                send_mode = pick_mode();
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p != 2 && $urandom_range(0, 15) == 0) begin
                    send_mode = pick_mode();
                end
                send_text(random_text_item());
            end
            stop_text();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
            $display("char_lcd_text_stream_writer regression: pass");
        end else begin
            $display("char_lcd_text_stream_writer regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/clcd_pkg.sv
design/clcd_decode.sv
design/clcd_emit.sv
design/char_lcd_text_stream_writer.sv
tb/tb_top.sv
